### sv/gdte_pkg.sv
package gdte_pkg;

	localparam int ACC_W  = 44;
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 10;
	localparam int YEAR_W = 12;
	localparam int ZONE_W = 27;
	localparam int OUT_W  = 42;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [YEAR_W-1:0] BASE_YEAR  = 12'd2000;
	// The only century in the reachable range of years that is not a leap year.
	localparam logic [YEAR_W-1:0] NO_LEAP_CENTURY = 12'd2100;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

	localparam logic [MUL_BW-1:0] MUL_ONE       = 10'd1;
	localparam logic [MUL_BW-1:0] HOURS_PER_DAY = 10'd24;
	localparam logic [MUL_BW-1:0] SIXTY         = 10'd60;
	localparam logic [MUL_BW-1:0] MS_PER_SEC    = 10'd1000;

	localparam logic signed [ZONE_W-1:0] ZONE_RESET_MS = 27'sd28800000;

	localparam logic [3:0] MONTH_FEB_IDX = 4'd1;
	localparam logic [3:0] MONTH_DEC     = 4'd12;

	typedef struct packed {
		logic [5:0] whole_second;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [4:0] day_of_month;
		logic [3:0] month_number;
		logic [6:0] two_digit_year;
	} gdte_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] epoch_ms;
		logic             date_ok;
	} gdte_res_t;

	typedef struct packed {
		logic [MUL_AW-1:0]       a;
		logic [MUL_BW-1:0]       b;
		logic signed [ACC_W-1:0] c;
	} mac_op_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'd0) && (y != NO_LEAP_CENTURY);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### sv/gps_date_to_epoch_ms.sv
// Converts a GPS date and UTC time of day into milliseconds since 1970-01-01,
// minus a programmable zone offset.
// The input channel (s_*) carries one request per transfer; the output channel
// (m_*) returns exactly one result per request, with date_ok on m_tuser.
// The zone offset is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A request is worked through in a sequencer that drives a single multiply-add unit,
// one step per year, one per month, then day, hour, minute, second and
// millisecond steps, so s_tready is low while a request is in work.
// The result goes into an output register, so a new request is accepted
// while a result still waits for m_tready.
// When the receiver stalls, the result holds and the sequencer waits once
// the next result is ready.
// Reset clears the sequencer and the output valid and loads the offset with
// 8 hours.
module gps_date_to_epoch_ms (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [26:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year[6:0], month[10:7], day[15:11], hour[20:16], minute[26:21], second[32:27]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// epoch_ms[41:0]
	output logic [47:0] m_tdata,
	// date_ok
	output logic        m_tuser
);
	import gdte_pkg::*;

	logic signed [ZONE_W-1:0] zone_q;
	gdte_in_t                 in_item;
	gdte_res_t                res;
	gdte_res_t                out_q;
	logic                     out_valid_q;
	logic                     res_valid;
	logic                     res_take;

	assign in_item  = gdte_in_t'(s_tdata[$bits(gdte_in_t)-1:0]);
	assign res_take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET_MS;
		end else if (cfg_we) begin
			zone_q <= $signed(cfg_wdata);
		end
	end

	gdte_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.zone      (zone_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.epoch_ms};
	assign m_tuser  = out_q.date_ok;

`ifndef NO_ASSERTIONS
	a_bad_date_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("invalid date returned a nonzero count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");
`endif

endmodule

### sv/gdte_mac.sv
module gdte_mac (
	input  gdte_pkg::mac_op_t                     op,
	output logic signed [gdte_pkg::ACC_W-1:0]     y
);
	import gdte_pkg::*;

	logic [MUL_AW+MUL_BW-1:0] prod;

	assign prod = MUL_AW'(op.a) * MUL_BW'(op.b);
	assign y    = $signed(ACC_W'(prod)) + op.c;

endmodule

### sv/gdte_seq.sv
module gdte_seq (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  gdte_pkg::gdte_in_t                    in_item,
	input  logic signed [gdte_pkg::ZONE_W-1:0]    zone,
	output logic                                  res_valid,
	input  logic                                  res_take,
	output gdte_pkg::gdte_res_t                   res
);
	import gdte_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_YEAR  = 9'b000000010,
		ST_MONTH = 9'b000000100,
		ST_DAY   = 9'b000001000,
		ST_HOUR  = 9'b000010000,
		ST_MIN   = 9'b000100000,
		ST_SEC   = 9'b001000000,
		ST_MS    = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                  state_q;
	gdte_in_t                in_q;
	logic [YEAR_W-1:0]       yr_q;
	logic [YEAR_W-1:0]       target_q;
	logic [3:0]              m_q;
	logic                    ok_q;
	logic signed [ACC_W-1:0] acc_q;

	mac_op_t                 op;
	logic signed [ACC_W-1:0] mac_y;
	logic                    fields_ok;
	logic                    more_months;
	logic [4:0]              month_add;

	gdte_mac u_mac (
		.op (op),
		.y  (mac_y)
	);

	assign fields_ok = (in_item.month_number != 4'd0) && (in_item.month_number <= MONTH_DEC)
		&& (in_item.day_of_month != 5'd0);
	assign more_months = (m_q + 4'd1) < in_q.month_number;
	assign month_add   = month_len(m_q)
		+ 5'((m_q == MONTH_FEB_IDX) && is_leap(target_q));

	always_comb begin
		op.a = acc_q[MUL_AW-1:0];
		op.b = MUL_ONE;
		op.c = '0;
		case (state_q)
			ST_YEAR: begin
				op.c = ACC_W'(DAYS_PER_YEAR) + ACC_W'(is_leap(yr_q));
			end
			ST_MONTH: begin
				op.c = ACC_W'(month_add);
			end
			ST_DAY: begin
				op.c = ACC_W'(in_q.day_of_month - 5'd1);
			end
			ST_HOUR: begin
				op.b = HOURS_PER_DAY;
				op.c = ACC_W'(in_q.hour_of_day);
			end
			ST_MIN: begin
				op.b = SIXTY;
				op.c = ACC_W'(in_q.minute_of_hour);
			end
			ST_SEC: begin
				op.b = SIXTY;
				op.c = ACC_W'(in_q.whole_second);
			end
			ST_MS: begin
				op.b = MS_PER_SEC;
				op.c = -(ACC_W'(zone));
			end
			default: begin
				op.c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ok_q     <= 1'b0;
			acc_q    <= '0;
			yr_q     <= EPOCH_YEAR;
			target_q <= EPOCH_YEAR;
			m_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_q     <= in_item;
						acc_q    <= '0;
						yr_q     <= EPOCH_YEAR;
						target_q <= BASE_YEAR + YEAR_W'(in_item.two_digit_year);
						m_q      <= '0;
						ok_q     <= fields_ok;
						state_q  <= fields_ok ? ST_YEAR : ST_DONE;
					end
				end
				ST_YEAR: begin
					if (yr_q == target_q) begin
						state_q <= ST_MONTH;
					end else begin
						acc_q <= mac_y;
						yr_q  <= yr_q + 12'd1;
					end
				end
				ST_MONTH: begin
					if (more_months) begin
						acc_q <= mac_y;
						m_q   <= m_q + 4'd1;
					end else begin
						state_q <= ST_DAY;
					end
				end
				ST_DAY: begin
					acc_q   <= mac_y;
					state_q <= ST_HOUR;
				end
				ST_HOUR: begin
					acc_q   <= mac_y;
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					acc_q   <= mac_y;
					state_q <= ST_SEC;
				end
				ST_SEC: begin
					acc_q   <= mac_y;
					state_q <= ST_MS;
				end
				ST_MS: begin
					acc_q   <= mac_y;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.date_ok = ok_q;
		if (acc_q[ACC_W-1]) begin
			res.epoch_ms = '0;
		end else if (acc_q[ACC_W-2:OUT_W] != '0) begin
			res.epoch_ms = '1;
		end else begin
			res.epoch_ms = acc_q[OUT_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_invalid_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !fields_ok) |=> (state_q == ST_DONE))
		else $error("invalid date did not go straight to the result");

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (yr_q <= target_q))
		else $error("year counter passed the target year");

	a_acc_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE && state_q != ST_IDLE) |-> !acc_q[ACC_W-1])
		else $error("accumulator negative before the offset step");

	a_ms_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MS) |=> (state_q == ST_DONE && ok_q))
		else $error("offset step did not end in a valid result");
`endif

endmodule
